>>> hw/rtl/gn2d_pkg.sv
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types, constants and helpers for the 2-D gradient noise block.
// ----------------------------------------------------------------------------
package gn2d_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    localparam int FRAC_W   = 16;        // Q0.16 fraction
    localparam int COORD_W  = 32;        // Q16.16 coordinate
    localparam int INDEX_W  = 12;
    localparam int FADE_W   = 17;        // 0 .. 1.0 in Q1.16
    localparam int OFS_W    = 18;        // corner offset, -1.0 .. +1.0
    localparam int DOT_W    = 19;        // dot product, -2.0 .. +2.0
    localparam int NOISE_W  = 19;        // Q2.16 result

    localparam int ONE_Q16  = 65536;
    localparam int HALF_Q16 = 32768;

    // fade polynomial 6t^5 - 15t^4 + 10t^3, factored as t^3 * (6t^2 - 15t + 10)
    localparam int FADE_K2  = 6;
    localparam int FADE_K1  = 15;
    localparam int FADE_K0  = 10;

    localparam int NOISE_MAX = 262143;
    localparam int NOISE_MIN = -262144;

    typedef logic [1:0] grad_t;  // bit 0: x negative, bit 1: y negative

    // Gradient components are +/-1, so the dot product is a signed add.
    function automatic logic signed [DOT_W-1:0] corner_dot(
        input grad_t                    g,
        input logic signed [OFS_W-1:0]  dx,
        input logic signed [OFS_W-1:0]  dy
    );
        logic signed [DOT_W-1:0] px;
        logic signed [DOT_W-1:0] py;
        px = g[0] ? -DOT_W'(dx) : DOT_W'(dx);
        py = g[1] ? -DOT_W'(dy) : DOT_W'(dy);
        return px + py;
    endfunction

endpackage

>>> hw/rtl/gn2d_ram.sv
// ----------------------------------------------------------------------------
// gn2d_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gn2d_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> hw/rtl/gn2d_fade.sv
// ----------------------------------------------------------------------------
// gn2d_fade
// Three-stage quintic fade 6t^5-15t^4+10t^3 on a Q0.16 fraction.
// ----------------------------------------------------------------------------
module gn2d_fade (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [gn2d_pkg::FRAC_W-1:0]   frac,
    output logic [gn2d_pkg::FADE_W-1:0]   fade
);

    localparam int SQ_W    = 2 * gn2d_pkg::FRAC_W + 1;
    localparam int T_W     = gn2d_pkg::FADE_W;
    localparam int CUBE_W  = T_W + gn2d_pkg::FRAC_W + 1;
    localparam int INNER_W = 22;   // signed, holds 6*t2 - 15*f + 10.0
    localparam int POS_W   = INNER_W - 1;
    localparam int PROD_W  = T_W + POS_W + 1;

    logic [gn2d_pkg::FRAC_W-1:0] f1_reg;
    logic [T_W-1:0]              t2_reg;
    logic [T_W-1:0]              t2_next;
    logic [T_W-1:0]              t3_reg;
    logic [T_W-1:0]              t3_next;
    logic [POS_W-1:0]            inner_reg;
    logic [POS_W-1:0]            inner_next;
    logic [T_W-1:0]              fade_reg;
    logic [T_W-1:0]              fade_next;

    logic [SQ_W-1:0]             sq;
    logic [CUBE_W-1:0]           cube;
    logic signed [INNER_W-1:0]   inner_s;
    logic [PROD_W-1:0]           prod;

    always_comb begin
        sq      = SQ_W'(frac) * SQ_W'(frac) + SQ_W'(gn2d_pkg::HALF_Q16);
        t2_next = T_W'(sq >> gn2d_pkg::FRAC_W);

        cube    = CUBE_W'(t2_reg) * CUBE_W'(f1_reg) + CUBE_W'(gn2d_pkg::HALF_Q16);
        t3_next = T_W'(cube >> gn2d_pkg::FRAC_W);

        inner_s = INNER_W'(gn2d_pkg::FADE_K2) * $signed(INNER_W'(t2_reg))
                - INNER_W'(gn2d_pkg::FADE_K1) * $signed(INNER_W'(f1_reg))
                + INNER_W'(gn2d_pkg::FADE_K0 * gn2d_pkg::ONE_Q16);
        inner_next = inner_s[INNER_W-1] ? '0 : inner_s[POS_W-1:0];

        prod      = PROD_W'(t3_reg) * PROD_W'(inner_reg) + PROD_W'(gn2d_pkg::HALF_Q16);
        fade_next = ((prod >> gn2d_pkg::FRAC_W) > PROD_W'(gn2d_pkg::ONE_Q16))
                  ? T_W'(gn2d_pkg::ONE_Q16)
                  : T_W'(prod >> gn2d_pkg::FRAC_W);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg    <= frac;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            inner_reg <= inner_next;
            fade_reg  <= fade_next;
        end
    end

    assign fade = fade_reg;

endmodule

>>> hw/rtl/gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2-D gradient noise: a load word writes one gradient, an evaluate word
// returns interpolated noise at a Q16.16 point.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    operation, x/y position, entry index,
//                                   gradient sign bits
//  m_       out  m_valid/m_ready    noise_value (Q2.16)
//
//  One word per cycle unless the output stalls; evaluate words pass stages v1..v6.
//  The table is split by row parity into two RAMs, each read at two columns,
//  so all four corners are fetched in the same cycle.
//  Reset clears only the pipeline valids; the table holds nothing until loaded.
//  A stalled result freezes the whole pipeline; s_ready = !m_valid | m_ready.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
    parameter int TABLE_SIDE = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic signed [gn2d_pkg::COORD_W-1:0]  s_x_position,
    input  logic signed [gn2d_pkg::COORD_W-1:0]  s_y_position,
    input  logic [gn2d_pkg::INDEX_W-1:0]         s_entry_index,
    input  logic                                 s_gradient_x_negative,
    input  logic                                 s_gradient_y_negative,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0]  m_noise_value
);

    localparam int LOG_SIDE   = $clog2(TABLE_SIDE);
    localparam int CELL_BITS  = 2 * LOG_SIDE;
    localparam int CELL_COUNT = TABLE_SIDE * TABLE_SIDE;
    localparam int BANK_DEPTH = CELL_COUNT / 2;
    localparam int BANK_AW    = CELL_BITS - 1;
    localparam int IDX_W      = (CELL_BITS > gn2d_pkg::INDEX_W) ? CELL_BITS
                                                                 : gn2d_pkg::INDEX_W;
    localparam int FW         = gn2d_pkg::FRAC_W;
    localparam int OW         = gn2d_pkg::OFS_W;
    localparam int DW         = gn2d_pkg::DOT_W;
    localparam int UW         = gn2d_pkg::FADE_W + 1;     // fade as signed
    localparam int DIFF1_W    = DW + 1;
    localparam int PROD1_W    = UW + DIFF1_W;
    localparam int L_W        = 21;
    localparam int DIFF2_W    = L_W + 1;
    localparam int PROD2_W    = UW + DIFF2_W;
    localparam int SUM_W      = 25;

    // row/2 * side + col, i.e. the cell index with the row parity bit removed
    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [LOG_SIDE-1:0] row,
        input logic [LOG_SIDE-1:0] col
    );
        logic [CELL_BITS-1:0] flat;
        flat = {row, col};
        return BANK_AW'(((flat >> (LOG_SIDE + 1)) << LOG_SIDE)
                        | (flat & CELL_BITS'(TABLE_SIDE - 1)));
    endfunction

    logic en;
    logic acc;
    logic acc_eval;

    assign en       = !m_valid || m_ready;
    assign s_ready  = en;
    assign acc      = s_valid && s_ready;
    assign acc_eval = acc && (gn2d_pkg::op_t'(s_operation) == gn2d_pkg::OP_EVAL);

    // ---------------- load ----------------
    logic [IDX_W-1:0]     idx_wide;
    logic [CELL_BITS-1:0] wr_cell;
    logic [LOG_SIDE-1:0]  wr_row;
    logic [LOG_SIDE-1:0]  wr_col;
    logic                 wr_ok;
    logic [BANK_AW-1:0]   wr_addr;
    gn2d_pkg::grad_t      wr_grad;
    logic                 wr_en_even;
    logic                 wr_en_odd;

    always_comb begin
        idx_wide   = IDX_W'(s_entry_index);
        wr_cell    = idx_wide[CELL_BITS-1:0];
        wr_row     = wr_cell[CELL_BITS-1:LOG_SIDE];
        wr_col     = wr_cell[LOG_SIDE-1:0];
        wr_ok      = 32'(s_entry_index) < 32'(CELL_COUNT);
        wr_addr    = bank_addr(wr_row, wr_col);
        wr_grad    = {s_gradient_y_negative, s_gradient_x_negative};
        wr_en_even = acc && (gn2d_pkg::op_t'(s_operation) == gn2d_pkg::OP_LOAD)
                     && wr_ok && !wr_row[0];
        wr_en_odd  = acc && (gn2d_pkg::op_t'(s_operation) == gn2d_pkg::OP_LOAD)
                     && wr_ok && wr_row[0];
    end

    // ---------------- corner fetch ----------------
    // Writes land at acceptance and reads issue at acceptance, in word order,
    // so a load is always visible to the next evaluate word.
    logic [LOG_SIDE-1:0] x0, x1, y0, y1;
    logic [LOG_SIDE-1:0] row_even, row_odd;
    logic [BANK_AW-1:0]  ev_a, ev_b, od_a, od_b;
    gn2d_pkg::grad_t     ev_da, ev_db, od_da, od_db;

    always_comb begin
        x0       = s_x_position[FW +: LOG_SIDE];
        y0       = s_y_position[FW +: LOG_SIDE];
        x1       = x0 + LOG_SIDE'(1);
        y1       = y0 + LOG_SIDE'(1);
        row_even = y0[0] ? y1 : y0;
        row_odd  = y0[0] ? y0 : y1;
        ev_a     = bank_addr(row_even, x0);
        ev_b     = bank_addr(row_even, x1);
        od_a     = bank_addr(row_odd, x0);
        od_b     = bank_addr(row_odd, x1);
    end

    gn2d_ram #(
        .WIDTH ($bits(gn2d_pkg::grad_t)),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .aclk      (aclk),
        .wr_en     (wr_en_even),
        .wr_addr   (wr_addr),
        .wr_data   (wr_grad),
        .rd_en     (en),
        .rd_addr_a (ev_a),
        .rd_addr_b (ev_b),
        .rd_data_a (ev_da),
        .rd_data_b (ev_db)
    );

    gn2d_ram #(
        .WIDTH ($bits(gn2d_pkg::grad_t)),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .aclk      (aclk),
        .wr_en     (wr_en_odd),
        .wr_addr   (wr_addr),
        .wr_data   (wr_grad),
        .rd_en     (en),
        .rd_addr_a (od_a),
        .rd_addr_b (od_b),
        .rd_data_a (od_da),
        .rd_data_b (od_db)
    );

    // ---------------- fades (stages 1..3) ----------------
    logic [gn2d_pkg::FADE_W-1:0] ux, uy;

    gn2d_fade u_fade_x (
        .aclk (aclk),
        .en   (en),
        .frac (s_x_position[FW-1:0]),
        .fade (ux)
    );

    gn2d_fade u_fade_y (
        .aclk (aclk),
        .en   (en),
        .frac (s_y_position[FW-1:0]),
        .fade (uy)
    );

    // ---------------- pipeline ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [FW-1:0] fx1_reg, fy1_reg;
    logic          ypar1_reg;

    logic signed [DW-1:0] p00_next, p10_next, p01_next, p11_next;
    logic signed [DW-1:0] p00_2_reg, p10_2_reg, p01_2_reg, p11_2_reg;
    logic signed [DW-1:0] p00_3_reg, p10_3_reg, p01_3_reg, p11_3_reg;

    logic signed [PROD1_W-1:0] prod_a_next, prod_b_next;
    logic signed [PROD1_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [DW-1:0]      p00_4_reg, p01_4_reg;
    logic [gn2d_pkg::FADE_W-1:0] uy4_reg, uy5_reg;

    logic signed [L_W-1:0]     l1_next, l2_next;
    logic signed [L_W-1:0]     l1_5_reg, l2_5_reg, l1_6_reg;
    logic signed [PROD2_W-1:0] prod_c_next, prod_c_reg;

    logic signed [SUM_W-1:0]              v_sum;
    logic signed [gn2d_pkg::NOISE_W-1:0]  noise_next, noise_reg;
    logic                                 m_valid_reg, m_valid_next;

    gn2d_pkg::grad_t g00, g10, g01, g11;
    logic signed [OW-1:0] dx0, dx1, dy0, dy1;

    logic signed [DIFF1_W-1:0] diff_a, diff_b;
    logic signed [UW-1:0]      ux_s, uy_s;
    logic signed [PROD1_W-1:0] rnd_a, rnd_b;
    logic signed [DIFF2_W-1:0] diff_c;
    logic signed [PROD2_W-1:0] rnd_c;

    always_comb begin
        // stage 1: corners from the banks, row y0 is the odd bank when y0 is odd
        g00 = ypar1_reg ? od_da : ev_da;
        g10 = ypar1_reg ? od_db : ev_db;
        g01 = ypar1_reg ? ev_da : od_da;
        g11 = ypar1_reg ? ev_db : od_db;
        dx0 = $signed(OW'(fx1_reg));
        dy0 = $signed(OW'(fy1_reg));
        dx1 = dx0 - OW'(gn2d_pkg::ONE_Q16);
        dy1 = dy0 - OW'(gn2d_pkg::ONE_Q16);
        p00_next = gn2d_pkg::corner_dot(g00, dx0, dy0);
        p10_next = gn2d_pkg::corner_dot(g10, dx1, dy0);
        p01_next = gn2d_pkg::corner_dot(g01, dx0, dy1);
        p11_next = gn2d_pkg::corner_dot(g11, dx1, dy1);

        // stage 3: x lerp products
        ux_s        = $signed({1'b0, ux});
        diff_a      = DIFF1_W'(p10_3_reg) - DIFF1_W'(p00_3_reg);
        diff_b      = DIFF1_W'(p11_3_reg) - DIFF1_W'(p01_3_reg);
        prod_a_next = PROD1_W'(ux_s) * PROD1_W'(diff_a);
        prod_b_next = PROD1_W'(ux_s) * PROD1_W'(diff_b);

        // stage 4: round half up, add base
        rnd_a   = (prod_a_reg + PROD1_W'(gn2d_pkg::HALF_Q16)) >>> FW;
        rnd_b   = (prod_b_reg + PROD1_W'(gn2d_pkg::HALF_Q16)) >>> FW;
        l1_next = L_W'(p00_4_reg) + L_W'(rnd_a);
        l2_next = L_W'(p01_4_reg) + L_W'(rnd_b);

        // stage 5: y lerp product
        uy_s        = $signed({1'b0, uy5_reg});
        diff_c      = DIFF2_W'(l2_5_reg) - DIFF2_W'(l1_5_reg);
        prod_c_next = PROD2_W'(uy_s) * PROD2_W'(diff_c);

        // stage 6: round, add, saturate
        rnd_c = (prod_c_reg + PROD2_W'(gn2d_pkg::HALF_Q16)) >>> FW;
        v_sum = SUM_W'(l1_6_reg) + SUM_W'(rnd_c);
        if (v_sum > SUM_W'(gn2d_pkg::NOISE_MAX)) begin
            noise_next = gn2d_pkg::NOISE_W'(gn2d_pkg::NOISE_MAX);
        end else if (v_sum < SUM_W'(gn2d_pkg::NOISE_MIN)) begin
            noise_next = gn2d_pkg::NOISE_W'(gn2d_pkg::NOISE_MIN);
        end else begin
            noise_next = v_sum[gn2d_pkg::NOISE_W-1:0];
        end

        m_valid_next = en ? v6_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                v1_reg <= acc_eval;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                v6_reg <= v5_reg;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx1_reg    <= s_x_position[FW-1:0];
            fy1_reg    <= s_y_position[FW-1:0];
            ypar1_reg  <= y0[0];
            p00_2_reg  <= p00_next;
            p10_2_reg  <= p10_next;
            p01_2_reg  <= p01_next;
            p11_2_reg  <= p11_next;
            p00_3_reg  <= p00_2_reg;
            p10_3_reg  <= p10_2_reg;
            p01_3_reg  <= p01_2_reg;
            p11_3_reg  <= p11_2_reg;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            p00_4_reg  <= p00_3_reg;
            p01_4_reg  <= p01_3_reg;
            uy4_reg    <= uy;
            l1_5_reg   <= l1_next;
            l2_5_reg   <= l2_next;
            uy5_reg    <= uy4_reg;
            prod_c_reg <= prod_c_next;
            l1_6_reg   <= l1_5_reg;
            noise_reg  <= noise_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = noise_reg;

    // ---------------- assertions ----------------
    // fade never exceeds 1.0
    a_fade_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (ux <= gn2d_pkg::FADE_W'(gn2d_pkg::ONE_Q16))
                && (uy <= gn2d_pkg::FADE_W'(gn2d_pkg::ONE_Q16)))
        else $error("fade out of range");

    // corner dot products p00 and p11 stay within +/-2.0
    a_dot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (p00_2_reg <= DW'(2 * gn2d_pkg::ONE_Q16))
                && (p00_2_reg >= -DW'(2 * gn2d_pkg::ONE_Q16))
                && (p11_2_reg <= DW'(2 * gn2d_pkg::ONE_Q16))
                && (p11_2_reg >= -DW'(2 * gn2d_pkg::ONE_Q16)))
        else $error("dot product out of range");

    // last stage moves into the output register when the pipe advances
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v6_reg |=> m_valid)
        else $error("result lost at output");

    // a load word never enters the evaluate pipeline
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && (gn2d_pkg::op_t'(s_operation) == gn2d_pkg::OP_LOAD) |=> !v1_reg)
        else $error("load word produced a result slot");

endmodule
